// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the translator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/tlbpt_pkg.sv =====
// Package with the fixed field widths of the address translator.
package tlbpt_pkg;

  localparam int unsigned VA_W         = 16;
  localparam int unsigned PA_W         = 15;
  localparam int unsigned FILL_PAGE_W  = 8;
  localparam int unsigned FILL_FRAME_W = 7;

endpackage

// ===== hw/rtl/tlbpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tlbpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tlb_page_table_translator_unit.sv =====
// Top level of the virtual-to-physical address translator with a FIFO-refilled TLB.
//
// The input channel carries one virtual address per beat; the output channel
// returns one result beat per address with the physical address, a TLB hit
// flag, a page fault flag and the page and frame to load on a fault.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The block holds one address at a time and raises in_stall_o
// from the cycle after it takes a beat until it returns to idle.
// A TLB hit steps through lookup, select, TLB frame read and done; a page
// table hit or a fault that takes a free frame through lookup, select,
// update and done; a fault that replaces a frame adds an evict step before
// update. When PAGE_COUNT is not a power of two, a reciprocal multiply, a
// multiply-back subtract and one correcting subtract first reduce the page
// number. The steps follow the serial registered RAM reads and writes.
// The result waits in an output register while out_stall_i is high; the
// sequencer does not leave its final step until that register is free.
// After reset the page table is cleared by a pass over all PAGE_COUNT
// entries, during which no input beat is taken.
`include "assert_macros.svh"

module tlb_page_table_translator_unit
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES  = 16,
  parameter int unsigned PAGE_COUNT   = 256,
  parameter int unsigned FRAME_COUNT  = 128,
  parameter int unsigned OFFSET_WIDTH = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [VA_W-1:0]         virtual_address_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PA_W-1:0]         phys_addr_o,
  output logic                    tlb_hit_o,
  output logic                    page_fault_o,
  output logic [FILL_PAGE_W-1:0]  fill_page_o,
  output logic [FILL_FRAME_W-1:0] fill_frame_o
);

  localparam int unsigned RAW_W     = VA_W - OFFSET_WIDTH;
  localparam int unsigned REM_W     = (RAW_W > 0) ? RAW_W : 1;
  localparam int unsigned PW        = $clog2(PAGE_COUNT);
  localparam int unsigned FW        = $clog2(FRAME_COUNT);
  localparam int unsigned TW        = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned CW        = $clog2(FRAME_COUNT + 1);
  localparam int unsigned DV_W      = REM_W + PW + 1;
  localparam int unsigned SW        = 2;
  localparam int unsigned RS        = REM_W + PW;
  localparam int unsigned RM        = (32'd1 << RS) / PAGE_COUNT;
  localparam int unsigned PR_W      = 2 * REM_W + 1;
  localparam bit          PAGE_POW2 = ((PAGE_COUNT & (PAGE_COUNT - 1)) == 0);

  localparam logic [SW-1:0] RED_MUL = 2'd0;
  localparam logic [SW-1:0] RED_SUB = 2'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LOOKUP,
    ST_SELECT,
    ST_EVICT,
    ST_UPDATE,
    ST_HITRD,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [PW-1:0]           clr_q;
  logic [OFFSET_WIDTH-1:0] off_q;
  logic [REM_W-1:0]        rem_q;
  logic [SW-1:0]           step_q;
  logic [PR_W-1:0]         prod_q;
  logic [PW-1:0]           tag_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]  tvalid_q;
  logic [TLB_ENTRIES-1:0]  match_q;
  logic [TW-1:0]           tfp_q;
  logic [FW-1:0]           ffp_q;
  logic [CW-1:0]           free_q;
  logic [FW-1:0]           frame_q;
  logic                    hit_q;
  logic                    fault_q;
  logic                    out_valid_q;
  logic [PA_W-1:0]         pa_q;
  logic                    out_hit_q;
  logic                    out_fault_q;
  logic [FILL_PAGE_W-1:0]  fpage_q;
  logic [FILL_FRAME_W-1:0] fframe_q;

  logic [REM_W-1:0]        raw_w;
  logic [REM_W-1:0]        quot_w;
  logic [DV_W-1:0]         dv_w;
  logic [DV_W-1:0]         rem_ext_w;
  logic                    sub_ok_w;
  logic [PW-1:0]           page_w;
  logic [PW-1:0]           old_page_w;
  logic [PW-1:0]           key_w;
  logic [TLB_ENTRIES-1:0]  match_w;
  logic [TW-1:0]           hit_idx_w;
  logic                    any_hit_w;
  logic                    out_free_w;

  logic                    pm_we;
  logic [PW-1:0]           pm_waddr;
  logic [FW:0]             pm_wdata;
  logic [FW:0]             pm_rdata;
  logic                    own_we;
  logic [PW-1:0]           own_rdata;
  logic                    tf_we;
  logic [FW-1:0]           tf_rdata;

  assign raw_w      = REM_W'({1'b0, virtual_address_i} >> OFFSET_WIDTH);
  assign quot_w     = REM_W'(prod_q >> RS);
  assign rem_ext_w  = DV_W'(rem_q);
  assign dv_w       = DV_W'(PAGE_COUNT);
  assign sub_ok_w   = (rem_ext_w >= dv_w);
  assign page_w     = PW'(rem_q);
  assign old_page_w = own_rdata;
  assign key_w      = (state_q == ST_EVICT) ? old_page_w : page_w;
  assign any_hit_w  = |match_q;
  assign out_free_w = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match_w[i] = tvalid_q[i] && (tag_q[i] == key_w);
    end
  end

  always_comb begin
    hit_idx_w = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx_w = TW'(i);
      end
    end
  end

  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = page_w;
    pm_wdata = {1'b1, frame_q};
    priority if (state_q == ST_CLEAR) begin
      pm_we    = 1'b1;
      pm_waddr = clr_q;
      pm_wdata = '0;
    end else if (state_q == ST_EVICT) begin
      pm_we    = 1'b1;
      pm_waddr = old_page_w;
      pm_wdata = '0;
    end else if (state_q == ST_UPDATE && fault_q) begin
      pm_we = 1'b1;
    end
  end

  assign own_we = (state_q == ST_UPDATE) && fault_q;
  assign tf_we  = (state_q == ST_UPDATE);

  tlbpt_ram #(
    .WIDTH (FW + 1),
    .DEPTH (PAGE_COUNT)
  ) u_page_map (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .raddr_i (page_w),
    .rdata_o (pm_rdata)
  );

  tlbpt_ram #(
    .WIDTH (PW),
    .DEPTH (FRAME_COUNT)
  ) u_frame_owner (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (ffp_q),
    .wdata_i (page_w),
    .raddr_i (ffp_q),
    .rdata_o (own_rdata)
  );

  tlbpt_ram #(
    .WIDTH (FW),
    .DEPTH (TLB_ENTRIES)
  ) u_tlb_frame (
    .clk_i   (clk_i),
    .we_i    (tf_we),
    .waddr_i (tfp_q),
    .wdata_i (frame_q),
    .raddr_i (hit_idx_w),
    .rdata_o (tf_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      tvalid_q    <= '0;
      tfp_q       <= '0;
      ffp_q       <= '0;
      free_q      <= CW'(FRAME_COUNT);
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_q == PW'(PAGE_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            off_q   <= virtual_address_i[OFFSET_WIDTH-1:0];
            rem_q   <= raw_w;
            step_q  <= RED_MUL;
            hit_q   <= 1'b0;
            fault_q <= 1'b0;
            state_q <= PAGE_POW2 ? ST_LOOKUP : ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (step_q == RED_MUL) begin
            prod_q <= PR_W'(rem_q) * PR_W'(RM);
            step_q <= RED_SUB;
          end else if (step_q == RED_SUB) begin
            rem_q  <= rem_q - quot_w * REM_W'(PAGE_COUNT);
            step_q <= step_q + 1'b1;
          end else begin
            if (sub_ok_w) begin
              rem_q <= REM_W'(rem_ext_w - dv_w);
            end
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          match_q <= match_w;
          state_q <= ST_SELECT;
        end
        ST_SELECT: begin
          if (any_hit_w) begin
            hit_q   <= 1'b1;
            state_q <= ST_HITRD;
          end else if (pm_rdata[FW]) begin
            frame_q <= pm_rdata[FW-1:0];
            state_q <= ST_UPDATE;
          end else begin
            fault_q <= 1'b1;
            frame_q <= ffp_q;
            if (free_q != '0) begin
              free_q  <= free_q - 1'b1;
              state_q <= ST_UPDATE;
            end else begin
              state_q <= ST_EVICT;
            end
          end
        end
        ST_EVICT: begin
          tvalid_q <= tvalid_q & ~match_w;
          state_q  <= ST_UPDATE;
        end
        ST_UPDATE: begin
          tvalid_q[tfp_q] <= 1'b1;
          tag_q[tfp_q]    <= page_w;
          tfp_q           <= (tfp_q == TW'(TLB_ENTRIES - 1)) ? '0 : tfp_q + 1'b1;
          if (fault_q) begin
            ffp_q <= (ffp_q == FW'(FRAME_COUNT - 1)) ? '0 : ffp_q + 1'b1;
          end
          state_q <= ST_DONE;
        end
        ST_HITRD: begin
          frame_q <= tf_rdata;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free_w) begin
            pa_q        <= PA_W'({frame_q, off_q});
            out_hit_q   <= hit_q;
            out_fault_q <= fault_q;
            fpage_q     <= fault_q ? FILL_PAGE_W'(page_w) : '0;
            fframe_q    <= fault_q ? FILL_FRAME_W'(frame_q) : '0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign phys_addr_o  = pa_q;
  assign tlb_hit_o    = out_hit_q;
  assign page_fault_o = out_fault_q;
  assign fill_page_o  = fpage_q;
  assign fill_frame_o = fframe_q;

  `ASSERT_CLK(a_hit_excludes_fault, out_valid_o |-> !(tlb_hit_o && page_fault_o))
  `ASSERT_CLK(a_tlb_tags_unique, (state_q == ST_SELECT) |-> $onehot0(match_q))
  `ASSERT_ALWAYS(a_free_in_range, free_q <= CW'(FRAME_COUNT))
  `ASSERT_CLK(a_accept_leaves_idle, (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))

endmodule
